[sv/aebp_pkg.sv]
// Shared types and constants for the arithmetic encoder bit packer.
// No dependencies; used by aebp_muldiv, aebp_pack and the top level.
package aebp_pkg;

  localparam int FIELD_W         = 31;
  localparam int BYTE_W          = 8;
  localparam int STATE_BITS_DEF  = 32;
  localparam int MAX_PENDING_DEF = 255;
  localparam int MAX_RESULTS     = 40;
  localparam int CNT_W           = $clog2(MAX_RESULTS + 1);

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_FINISH = 1'b1
  } req_type_t;

  // sequencer -> packer
  typedef struct packed {
    logic push;
    logic bit_val;
    logic item_end;
  } pk_cmd_t;

  // packer -> sequencer
  typedef struct packed {
    logic ready;
    logic empty;
    logic hold_v;
  } pk_stat_t;

endpackage

[sv/arithmetic_encoder_bit_packer.sv]
// Arithmetic encoder with MSB-first byte packer; one word in flight at a time.
// Encode: both bounds are found bit-serially, then emitted bits go out with their
// pending bits and underflow steps are taken. Finish: a one bit, then zero bits
// to fill the byte. Each item then closes. Output stalls hold the sequencer.
// Synchronous active-low reset sets the interval to [0, all ones] and clears
// the pending count, overflow flag, packer and output register.
module arithmetic_encoder_bit_packer #(
  parameter int STATE_BITS  = aebp_pkg::STATE_BITS_DEF,
  parameter int MAX_PENDING = aebp_pkg::MAX_PENDING_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [aebp_pkg::FIELD_W-1:0]  in_total,
  input  logic [aebp_pkg::FIELD_W-1:0]  in_sym_low,
  input  logic [aebp_pkg::FIELD_W-1:0]  in_sym_high,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [aebp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last,
  output logic                          out_pending_overflow
);

  localparam int SB  = STATE_BITS;
  localparam int RW  = STATE_BITS + 1;
  localparam int FW  = aebp_pkg::FIELD_W;
  localparam int FW1 = aebp_pkg::FIELD_W + 1;
  localparam int GW  = $clog2(STATE_BITS + 1);
  localparam int PW  = (MAX_PENDING > 1) ? $clog2(MAX_PENDING + 1) : 1;
  localparam logic [FW1-1:0] MAX_TOTAL = FW1'((64'd1 << (STATE_BITS - 2)) + 64'd2);
  localparam logic [SB-1:0]  HALF      = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_LO,
    S_DIV_HI,
    S_RENORM,
    S_PEND,
    S_UNDER,
    S_FIN_ONE,
    S_FIN_ZERO,
    S_END
  } state_t;

  state_t        state_r, state_nxt;
  logic [SB-1:0] low_r, low_nxt;
  logic [SB-1:0] high_r, high_nxt;
  logic [SB-1:0] nlow_r, nlow_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic          ovf_r, ovf_nxt;
  logic [GW-1:0] guard_r, guard_nxt;
  logic          pbit_r, pbit_nxt;
  logic [FW-1:0] total_r, total_nxt;
  logic [FW-1:0] shi_r, shi_nxt;

  logic          accept;
  logic          bad_req;
  logic          top_eq;
  logic          straddle;
  logic          guard_ok;
  logic [RW-1:0] range_w;
  logic [RW-1:0] sum_lo;
  logic [RW-1:0] sum_hi;

  logic          md_start;
  logic [FW-1:0] md_mult;
  logic [FW-1:0] md_div;
  logic          md_done;
  logic [RW-1:0] md_quot;

  aebp_pkg::pk_cmd_t  pk_cmd;
  aebp_pkg::pk_stat_t pk_stat;

  aebp_muldiv #(
    .RW (RW)
  ) u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (md_start),
    .mult    (md_mult),
    .range_i (range_w),
    .divisor (md_div),
    .done    (md_done),
    .quot    (md_quot)
  );

  aebp_pack u_pack (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (pk_cmd),
    .ovf_in               (ovf_r),
    .stat                 (pk_stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_byte             (out_byte),
    .out_last             (out_last),
    .out_pending_overflow (out_pending_overflow)
  );

  always_comb begin
    in_stall = (state_r != S_IDLE);
    accept   = in_valid && (state_r == S_IDLE);
    bad_req  = (in_total == '0) || ({1'b0, in_total} > MAX_TOTAL) ||
               (in_sym_low >= in_sym_high) || (in_sym_high > in_total);
    // wraps to zero when high sits one below low, as the interval math does
    range_w  = {1'b0, high_r} - {1'b0, low_r} + RW'(1);
    top_eq   = (low_r[SB-1] == high_r[SB-1]);
    straddle = low_r[SB-2] && !high_r[SB-2];
    guard_ok = (guard_r < GW'(STATE_BITS));
    sum_lo   = {1'b0, low_r} + md_quot;
    sum_hi   = {1'b0, low_r} + md_quot - RW'(1);
    md_mult  = (state_r == S_IDLE) ? in_sym_low : shi_r;
    md_div   = (state_r == S_IDLE) ? in_total : total_r;

    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    nlow_nxt  = nlow_r;
    pend_nxt  = pend_r;
    ovf_nxt   = ovf_r;
    guard_nxt = guard_r;
    pbit_nxt  = pbit_r;
    total_nxt = total_r;
    shi_nxt   = shi_r;
    md_start  = 1'b0;
    pk_cmd    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          total_nxt = in_total;
          shi_nxt   = in_sym_high;
          if (in_req_type == aebp_pkg::REQ_FINISH) begin
            state_nxt = S_FIN_ONE;
          end else if (!bad_req) begin
            md_start  = 1'b1;
            state_nxt = S_DIV_LO;
          end
        end
      end
      S_DIV_LO: begin
        if (md_done) begin
          nlow_nxt  = sum_lo[SB-1:0];
          md_start  = 1'b1;
          state_nxt = S_DIV_HI;
        end
      end
      S_DIV_HI: begin
        if (md_done) begin
          low_nxt   = nlow_r;
          high_nxt  = sum_hi[SB-1:0];
          guard_nxt = '0;
          state_nxt = S_RENORM;
        end
      end
      S_RENORM: begin
        if (guard_ok && top_eq) begin
          pk_cmd.push    = 1'b1;
          pk_cmd.bit_val = low_r[SB-1];
          if (pk_stat.ready) begin
            // shift now; the pending bits go out before the next compare
            low_nxt   = {low_r[SB-2:0], 1'b0};
            high_nxt  = {high_r[SB-2:0], 1'b1};
            guard_nxt = guard_r + GW'(1);
            pbit_nxt  = !low_r[SB-1];
            if (pend_r != '0) begin
              state_nxt = S_PEND;
            end
          end
        end else begin
          guard_nxt = '0;
          state_nxt = S_UNDER;
        end
      end
      S_PEND: begin
        pk_cmd.push    = 1'b1;
        pk_cmd.bit_val = pbit_r;
        if (pk_stat.ready) begin
          pend_nxt = pend_r - PW'(1);
          if (pend_r == PW'(1)) begin
            state_nxt = S_RENORM;
          end
        end
      end
      S_UNDER: begin
        if (guard_ok && straddle) begin
          if (pend_r >= PW'(MAX_PENDING)) begin
            ovf_nxt = 1'b1;
          end else begin
            pend_nxt = pend_r + PW'(1);
          end
          low_nxt   = {low_r[SB-2:0], 1'b0} ^ HALF;
          high_nxt  = {high_r[SB-2:0], 1'b0} | HALF | SB'(1);
          guard_nxt = guard_r + GW'(1);
        end else begin
          state_nxt = S_END;
        end
      end
      S_FIN_ONE: begin
        pk_cmd.push    = 1'b1;
        pk_cmd.bit_val = 1'b1;
        if (pk_stat.ready) begin
          state_nxt = S_FIN_ZERO;
        end
      end
      S_FIN_ZERO: begin
        if (pk_stat.empty) begin
          state_nxt = S_END;
        end else begin
          pk_cmd.push    = 1'b1;
          pk_cmd.bit_val = 1'b0;
        end
      end
      S_END: begin
        pk_cmd.item_end = 1'b1;
        if (pk_stat.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      low_r   <= '0;
      high_r  <= '1;
      pend_r  <= '0;
      ovf_r   <= 1'b0;
      guard_r <= '0;
    end else begin
      state_r <= state_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
      pend_r  <= pend_nxt;
      ovf_r   <= ovf_nxt;
      guard_r <= guard_nxt;
      nlow_r  <= nlow_nxt;
      pbit_r  <= pbit_nxt;
      total_r <= total_nxt;
      shi_r   <= shi_nxt;
    end
  end

  // an item only closes once its held word has gone to the output register
  a_idle_no_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pk_stat.hold_v)
    else $error("held word left over in idle");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PW'(MAX_PENDING))
    else $error("pending count above limit");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |=> ovf_r)
    else $error("overflow flag cleared");

  a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
    guard_r <= GW'(STATE_BITS))
    else $error("renorm step count out of range");

endmodule

[sv/aebp_muldiv.sv]
// Bit-serial multiply-divide unit: quot = floor(mult * range_i / divisor).
// One bit of range_i per cycle, MSB first, remainder kept below divisor.
// Depends on aebp_pkg.
module aebp_muldiv #(
  parameter int RW = aebp_pkg::STATE_BITS_DEF + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [aebp_pkg::FIELD_W-1:0] mult,
  input  logic [RW-1:0]              range_i,
  input  logic [aebp_pkg::FIELD_W-1:0] divisor,
  output logic                       done,
  output logic [RW-1:0]              quot
);

  localparam int FW = aebp_pkg::FIELD_W;
  localparam int TW = FW + 2;
  localparam int SW = $clog2(RW + 1);

  logic          busy_r;
  logic          done_r;
  logic [SW-1:0] step_r;
  logic [RW-1:0] rng_r;
  logic [RW-1:0] quot_r;
  logic [FW-1:0] rem_r;
  logic [FW-1:0] mul_r;
  logic [FW-1:0] div_r;

  logic [TW-1:0] t_sum;
  logic [TW-1:0] t_red;
  logic [TW-1:0] div1;
  logic [TW-1:0] div2;
  logic [1:0]    digit;
  logic [RW-1:0] quot_nxt;

  // rem < divisor and mult <= divisor, so 2*rem + mult < 3*divisor:
  // the quotient digit is 0, 1 or 2.
  always_comb begin
    div1  = {2'b00, div_r};
    div2  = {1'b0, div_r, 1'b0};
    t_sum = {1'b0, rem_r, 1'b0} + (rng_r[RW-1] ? {2'b00, mul_r} : '0);
    if (t_sum >= div2) begin
      t_red = t_sum - div2;
      digit = 2'd2;
    end else if (t_sum >= div1) begin
      t_red = t_sum - div1;
      digit = 2'd1;
    end else begin
      t_red = t_sum;
      digit = 2'd0;
    end
    quot_nxt = {quot_r[RW-2:0], 1'b0} + RW'(digit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= SW'(RW);
      end else if (busy_r) begin
        step_r <= step_r - SW'(1);
        if (step_r == SW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rng_r  <= range_i;
      mul_r  <= mult;
      div_r  <= divisor;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      rng_r  <= {rng_r[RW-2:0], 1'b0};
      rem_r  <= t_red[FW-1:0];
      quot_r <= quot_nxt;
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[sv/aebp_pack.sv]
// MSB-first bit packer with a one-word hold stage and the output register.
// The hold stage lets the last word of an item be tagged once the item ends.
// Depends on aebp_pkg.
module aebp_pack (
  input  logic                         clk,
  input  logic                         rst_n,
  input  aebp_pkg::pk_cmd_t            cmd,
  input  logic                         ovf_in,
  output aebp_pkg::pk_stat_t           stat,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [aebp_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_last,
  output logic                         out_pending_overflow
);

  localparam int BW = aebp_pkg::BYTE_W;
  localparam int CW = aebp_pkg::CNT_W;

  logic [BW-1:0] pb_r, pb_nxt;
  logic [2:0]    bf_r, bf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          hold_v_r, hold_v_nxt;
  logic [BW-1:0] hold_byte_r, hold_byte_nxt;
  logic          hold_ovf_r, hold_ovf_nxt;
  logic          ov_r, ov_nxt;
  logic [BW-1:0] ob_r, ob_nxt;
  logic          ol_r, ol_nxt;
  logic          oo_r, oo_nxt;

  logic          out_free;
  logic          rdy;
  logic          do_push;
  logic          completes;
  logic          keep;
  logic          ending;
  logic [BW-1:0] shifted;

  always_comb begin
    out_free  = !ov_r || !out_stall;
    rdy       = out_free || !hold_v_r;
    do_push   = cmd.push && rdy;
    shifted   = {pb_r[BW-2:0], cmd.bit_val};
    completes = do_push && (bf_r == 3'd7);
    // words beyond the per-item limit are dropped
    keep      = completes && (cnt_r < CW'(aebp_pkg::MAX_RESULTS));
    ending    = cmd.item_end && rdy;

    pb_nxt        = pb_r;
    bf_nxt        = bf_r;
    cnt_nxt       = cnt_r;
    hold_v_nxt    = hold_v_r;
    hold_byte_nxt = hold_byte_r;
    hold_ovf_nxt  = hold_ovf_r;
    ov_nxt        = ov_r && out_stall;
    ob_nxt        = ob_r;
    ol_nxt        = ol_r;
    oo_nxt        = oo_r;

    if (do_push) begin
      pb_nxt = completes ? '0 : shifted;
      bf_nxt = bf_r + 3'd1;
    end
    if (keep) begin
      cnt_nxt = cnt_r + CW'(1);
      if (hold_v_r) begin
        ov_nxt = 1'b1;
        ob_nxt = hold_byte_r;
        ol_nxt = 1'b0;
        oo_nxt = hold_ovf_r;
      end
      hold_v_nxt    = 1'b1;
      hold_byte_nxt = shifted;
      hold_ovf_nxt  = ovf_in;
    end
    if (ending) begin
      cnt_nxt = '0;
      if (hold_v_r) begin
        ov_nxt     = 1'b1;
        ob_nxt     = hold_byte_r;
        ol_nxt     = 1'b1;
        oo_nxt     = hold_ovf_r;
        hold_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pb_r     <= '0;
      bf_r     <= '0;
      cnt_r    <= '0;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      pb_r     <= pb_nxt;
      bf_r     <= bf_nxt;
      cnt_r    <= cnt_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_byte_r <= hold_byte_nxt;
    hold_ovf_r  <= hold_ovf_nxt;
    ob_r        <= ob_nxt;
    ol_r        <= ol_nxt;
    oo_r        <= oo_nxt;
  end

  assign stat.ready  = rdy;
  assign stat.empty  = (bf_r == 3'd0);
  assign stat.hold_v = hold_v_r;

  assign out_valid            = ov_r;
  assign out_byte             = ob_r;
  assign out_last             = ol_r;
  assign out_pending_overflow = oo_r;

endmodule

[dv/tb_top.sv]
// Testbench for arithmetic_encoder_bit_packer: directed and random encode/finish words,
// with a built-in interval coder and byte packer predicting every code byte.
// Depends on aebp_pkg and the RTL top level only.
module tb_top;

  localparam int             SB             = aebp_pkg::STATE_BITS_DEF;
  localparam int             FW             = aebp_pkg::FIELD_W;
  localparam logic [31:0]    HALF           = 32'h8000_0000;
  localparam logic [31:0]    QUARTER        = 32'h4000_0000;
  localparam logic [30:0]    MAX_TOTAL      = 31'h4000_0002;
  localparam int             HOLD_CYCLES    = 300;
  localparam int             DRAIN_CYCLES   = 600;
  localparam int             WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [aebp_pkg::BYTE_W-1:0] data;
    logic                        last;
    logic                        ovf;
  } code_byte_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_req_type = 1'b0;
  logic [FW-1:0]               in_total = '0;
  logic [FW-1:0]               in_sym_low = '0;
  logic [FW-1:0]               in_sym_high = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [aebp_pkg::BYTE_W-1:0] out_byte;
  logic                        out_last;
  logic                        out_pending_overflow;

  // predicted coder and packer state
  logic [31:0]        ac_lo = '0;
  logic [31:0]        ac_hi = '1;
  int unsigned        pend = 0;
  logic [7:0]         pk_byte = '0;
  int                 pk_bits = 0;
  logic               ovf_seen = 1'b0;
  int                 item_bytes = 0;

  code_byte_t         exp_bytes[$];
  int                 err_cnt = 0;
  int                 idle_cycles = 0;
  bit                 tx_gaps = 1'b0;
  bit                 rx_gaps = 1'b0;
  bit                 hold_req = 1'b0;

  arithmetic_encoder_bit_packer DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_total             (in_total),
    .in_sym_low           (in_sym_low),
    .in_sym_high          (in_sym_high),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_byte             (out_byte),
    .out_last             (out_last),
    .out_pending_overflow (out_pending_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [FW-1:0] rand_field();
    logic [31:0] r;
    r = $urandom;
    return r[FW-1:0];
  endfunction

  function automatic void pack_bit(input logic b);
    code_byte_t cb;
    pk_byte = {pk_byte[6:0], b};
    pk_bits++;
    if (pk_bits == 8) begin
      if (item_bytes < aebp_pkg::MAX_RESULTS) begin
        cb.data = pk_byte;
        cb.last = 1'b0;
        cb.ovf  = ovf_seen;
        exp_bytes.push_back(cb);
        item_bytes++;
      end
      pk_byte = '0;
      pk_bits = 0;
    end
  endfunction

  function automatic void predict_code_bytes(input aebp_pkg::req_type_t req,
                                             input logic [FW-1:0] tot,
                                             input logic [FW-1:0] slo,
                                             input logic [FW-1:0] shi);
    logic [63:0] rng, nl, nh;
    int          g, n0;
    logic        b;
    code_byte_t  cb;
    n0 = exp_bytes.size();
    item_bytes = 0;
    if (req == aebp_pkg::REQ_FINISH) begin
      pack_bit(1'b1);
      while (pk_bits != 0) pack_bit(1'b0);
    end else begin
      // malformed encode words leave everything untouched
      if (tot == '0 || tot > MAX_TOTAL || slo >= shi || shi > tot) return;
      rng = {32'd0, ac_hi} - {32'd0, ac_lo} + 64'd1;
      nl  = {32'd0, ac_lo} + ({33'd0, slo} * rng) / {33'd0, tot};
      nh  = {32'd0, ac_lo} + ({33'd0, shi} * rng) / {33'd0, tot} - 64'd1;
      ac_lo = nl[31:0];
      ac_hi = nh[31:0];
      g = 0;
      while (g < SB && ((ac_lo ^ ac_hi) & HALF) == '0) begin
        b = ac_lo[31];
        pack_bit(b);
        while (pend > 0) begin
          pack_bit(~b);
          pend--;
        end
        ac_lo = ac_lo << 1;
        ac_hi = (ac_hi << 1) | 32'd1;
        g++;
      end
      g = 0;
      while (g < SB && (ac_lo & ~ac_hi & QUARTER) != '0) begin
        if (pend >= aebp_pkg::MAX_PENDING_DEF) ovf_seen = 1'b1;
        else pend++;
        ac_lo = (ac_lo << 1) ^ HALF;
        ac_hi = ((ac_hi ^ HALF) << 1) | HALF | 32'd1;
        g++;
      end
    end
    if (exp_bytes.size() > n0) begin
      cb = exp_bytes.pop_back();
      cb.last = 1'b1;
      exp_bytes.push_back(cb);
    end
  endfunction

  task automatic send_word(input aebp_pkg::req_type_t req, input logic [FW-1:0] tot,
                           input logic [FW-1:0] slo, input logic [FW-1:0] shi);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_total    <= tot;
    in_sym_low  <= slo;
    in_sym_high <= shi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_code_bytes(req, tot, slo, shi);
  endtask

  task automatic send_random_symbol();
    int            w;
    logic [FW-1:0] t, a, c;
    w = $urandom_range(1, 31);
    if (w == 31) t = MAX_TOTAL - FW'($urandom_range(0, 2));
    else t = FW'($urandom_range(1, 32'd1 << w));
    a = FW'($urandom_range(0, 32'(t) - 1));
    if ($urandom_range(0, 3) == 0) c = a + 1'b1;
    else c = FW'($urandom_range(32'(a) + 1, 32'(t)));
    send_word(aebp_pkg::REQ_ENCODE, t, a, c);
  endtask

  task automatic test_interval_extremes();
    send_word(aebp_pkg::REQ_ENCODE, 31'd1, 31'd0, 31'd1);
    send_word(aebp_pkg::REQ_ENCODE, MAX_TOTAL, 31'd0, 31'd1);
    send_word(aebp_pkg::REQ_ENCODE, MAX_TOTAL, MAX_TOTAL - 1'b1, MAX_TOTAL);
    send_word(aebp_pkg::REQ_ENCODE, MAX_TOTAL, 31'd0, MAX_TOTAL);
    send_word(aebp_pkg::REQ_ENCODE, 31'd2, 31'd0, 31'd1);
    send_word(aebp_pkg::REQ_ENCODE, 31'd2, 31'd1, 31'd2);
    send_word(aebp_pkg::REQ_ENCODE, 31'd3, 31'd1, 31'd2);
    send_word(aebp_pkg::REQ_ENCODE, 31'h4000_0000, 31'h3FFF_FFFF, 31'h4000_0000);
    send_word(aebp_pkg::REQ_ENCODE, 31'h4000_0001, 31'h4000_0000, 31'h4000_0001);
    send_word(aebp_pkg::REQ_ENCODE, MAX_TOTAL, 31'h4000_0001, 31'h4000_0002);
  endtask

  task automatic test_malformed_words();
    send_word(aebp_pkg::REQ_ENCODE, 31'd0, 31'd0, 31'd1);
    send_word(aebp_pkg::REQ_ENCODE, MAX_TOTAL + 1'b1, 31'd0, 31'd1);
    send_word(aebp_pkg::REQ_ENCODE, 31'h7FFF_FFFF, 31'd0, 31'd1);
    send_word(aebp_pkg::REQ_ENCODE, 31'd10, 31'd5, 31'd5);
    send_word(aebp_pkg::REQ_ENCODE, 31'd10, 31'd7, 31'd3);
    send_word(aebp_pkg::REQ_ENCODE, 31'd10, 31'd0, 31'd11);
    send_word(aebp_pkg::REQ_ENCODE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(aebp_pkg::REQ_ENCODE, 31'd5, 31'd2, 31'd3);
  endtask

  task automatic test_finish_flush();
    send_word(aebp_pkg::REQ_FINISH, 31'd0, 31'd0, 31'd0);
    // packer now empty: finish gives a lone marker byte
    send_word(aebp_pkg::REQ_FINISH, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(aebp_pkg::REQ_ENCODE, 31'd7, 31'd2, 31'd5);
    send_word(aebp_pkg::REQ_FINISH, rand_field(), rand_field(), rand_field());
  endtask

  task automatic test_random_stream(input int n);
    int i, sel;
    for (i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) send_word(aebp_pkg::REQ_FINISH, rand_field(), rand_field(), rand_field());
      else if (sel < 14) send_word(aebp_pkg::REQ_ENCODE, rand_field(), rand_field(),
                                   rand_field());
      else send_random_symbol();
    end
  endtask

  // receiver holds off long enough for the single in-flight word to block the input
  task automatic test_output_backpressure();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 10; i++) send_random_symbol();
  endtask

  // narrow symbols straddling the midpoint pile up underflow bits until the count saturates
  task automatic test_pending_saturation();
    logic [63:0] span, k, t;
    logic [30:0] lo_s, hi_s;
    int          n;
    t = 64'd1 << 28;
    n = 0;
    while (!ovf_seen && n < 40) begin
      span = {32'd0, ac_hi} - {32'd0, ac_lo} + 64'd1;
      k = ((64'h8000_0000 - {32'd0, ac_lo}) * t) / span;
      lo_s = (k == 0) ? 31'd0 : 31'(k - 1);
      hi_s = (k + 2 > t) ? 31'(t) : 31'(k + 2);
      send_word(aebp_pkg::REQ_ENCODE, 31'(t), lo_s, hi_s);
      n++;
    end
    // a symbol at the bottom edge flushes the whole pending run
    send_word(aebp_pkg::REQ_ENCODE, MAX_TOTAL, 31'd0, 31'd1);
    send_word(aebp_pkg::REQ_FINISH, rand_field(), rand_field(), rand_field());
  endtask

  always begin
    @(posedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_stall <= 1'b0;
      hold_req = 1'b0;
    end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 11)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : byte_check
    code_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_bytes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual byte %h last %b ovf %b",
                 $time, out_byte, out_last, out_pending_overflow);
        err_cnt++;
      end else begin
        want = exp_bytes.pop_front();
        if (out_byte !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
          err_cnt++;
        end
        if (out_last !== want.last) begin
          $display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
          err_cnt++;
        end
        if (out_pending_overflow !== want.ovf) begin
          $display("%0t: out_pending_overflow expected %b actual %b",
                   $time, want.ovf, out_pending_overflow);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    test_interval_extremes();
    test_malformed_words();
    test_finish_flush();
    test_random_stream(60);
    test_output_backpressure();
    test_pending_saturation();
    test_random_stream(60);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_stream(40);
    in_valid <= 1'b0;
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && exp_bytes.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
